[rtl/dna_pkg.sv]
// ----------------------------------------------------------------------------
// dna_pkg
// Shared types and codes for the dual number arithmetic pipeline.
// ----------------------------------------------------------------------------
package dna_pkg;

	// quotient bits produced per divide (33 digits; the value range check is done apart)
	localparam int STEPS = 33;

	typedef enum logic [2:0] {
		MODE_NEG   = 3'd0,
		MODE_ADD   = 3'd1,
		MODE_SUB   = 3'd2,
		MODE_MUL   = 3'd3,
		MODE_DIV   = 3'd4,
		MODE_SCALE = 3'd5,
		MODE_INV   = 3'd6,
		MODE_NONE  = 3'd7
	} mode_t;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_DZ  = 2'd1;
	localparam logic [1:0] STAT_SAT = 2'd2;

	typedef enum logic [1:0] {
		KIND_CALC,
		KIND_DZ,
		KIND_ZERO
	} kind_t;

	// one result part entering a divide lane; non-divide parts ride in num
	typedef struct packed {
		logic        div;
		logic        neg;
		logic [63:0] num;
		logic [63:0] den;
	} lane_in_t;

	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} lane_out_t;

endpackage

[rtl/dna_div_lane.sv]
// ----------------------------------------------------------------------------
// dna_div_lane
// Pipelined restoring divider, one quotient digit per stage. Computes
// floor(num * 2^FRAC_BITS / den); quotients of 2^33 or more come out as all
// ones. Parts that are not divided pass through with the same latency.
// ----------------------------------------------------------------------------
module dna_div_lane
	import dna_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  lane_in_t  din,
	output lane_out_t dout
);

	localparam int SHR = STEPS - FRAC_BITS;

	logic [63:0]      rem_s  [0:STEPS];
	logic [63:0]      den_s  [0:STEPS];
	logic [63:0]      pass_s [0:STEPS];
	logic [STEPS-1:0] quo_s  [0:STEPS];
	logic [STEPS-1:0] xlo_s  [0:STEPS];
	logic             ovf_s  [0:STEPS];
	logic             div_s  [0:STEPS];
	logic             neg_s  [0:STEPS];

	logic [63:0] top0;
	logic [63:0] shl0;

	// dividend is num << FRAC_BITS; its bits above the quotient window form the
	// starting remainder, which must be below den or the quotient is too large
	assign top0 = din.num >> SHR;
	assign shl0 = din.num << FRAC_BITS;

	always_ff @(posedge clk) begin
		rem_s[0]  <= top0;
		den_s[0]  <= din.den;
		pass_s[0] <= din.num;
		quo_s[0]  <= '0;
		xlo_s[0]  <= shl0[STEPS-1:0];
		ovf_s[0]  <= (top0 >= din.den);
		div_s[0]  <= din.div;
		neg_s[0]  <= din.neg;
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [63:0] trial;
		logic [64:0] diff;

		assign trial = {rem_s[k-1][62:0], xlo_s[k-1][STEPS-k]};
		assign diff  = {1'b0, trial} - {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			rem_s[k]  <= diff[64] ? trial : diff[63:0];
			quo_s[k]  <= {quo_s[k-1][STEPS-2:0], ~diff[64]};
			den_s[k]  <= den_s[k-1];
			pass_s[k] <= pass_s[k-1];
			xlo_s[k]  <= xlo_s[k-1];
			ovf_s[k]  <= ovf_s[k-1];
			div_s[k]  <= div_s[k-1];
			neg_s[k]  <= neg_s[k-1];
		end
	end

	always_comb begin
		dout.neg = neg_s[STEPS];
		if (!div_s[STEPS]) begin
			dout.mag = pass_s[STEPS];
		end else if (ovf_s[STEPS]) begin
			dout.mag = '1;
		end else begin
			dout.mag = 64'(quo_s[STEPS]);
		end
	end

endmodule

[rtl/dual_number_alu.sv]
// ----------------------------------------------------------------------------
// dual_number_alu
// done pulses once a taken start has passed the product, sum, divide and output registers.
// Throughput: one transaction per cycle; busy stays low, the result side
// cannot stall. Depth is set by the 33 one-digit divide stages.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module dual_number_alu
	import dna_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         mode,
	input  logic signed [31:0] a_real,
	input  logic signed [31:0] a_deriv,
	input  logic signed [31:0] b_real,
	input  logic signed [31:0] b_deriv,
	input  logic signed [31:0] factor,
	output logic               done,
	output logic signed [31:0] res_real,
	output logic signed [31:0] res_deriv,
	output logic [1:0]         status
);

	function automatic logic [64:0] sx32(input logic [31:0] x);
		return {{33{x[31]}}, x};
	endfunction

	function automatic logic [64:0] sx64(input logic [63:0] x);
		return {x[63], x};
	endfunction

	// {sign, magnitude} of a 65-bit signed value
	function automatic logic [64:0] smag(input logic [64:0] v);
		logic [64:0] a;
		a = v[64] ? (65'd0 - v) : v;
		return {v[64], a[63:0]};
	endfunction

	// {saturated, value} of a sign-magnitude part
	function automatic logic [32:0] to_q(input logic neg, input logic [63:0] mag);
		logic [32:0] r;
		if (!neg) begin
			if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
			else                     r = {1'b0, mag[31:0]};
		end else begin
			if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
			else                     r = {1'b0, 32'd0 - mag[31:0]};
		end
		return r;
	endfunction

	assign busy = 1'b0;

	// ---------------- stage 1: products ----------------
	mode_t              mode_in;
	logic signed [31:0] m0a, m0b, m1a, m1b;
	logic signed [63:0] p0, p1, p2;

	assign mode_in = mode_t'(mode);

	always_comb begin
		m0a = a_real;
		m0b = b_real;
		m1a = a_real;
		m1b = b_deriv;
		case (mode_in)
			MODE_DIV: begin
				m0a = b_real;
				m0b = b_real;
			end
			MODE_SCALE: begin
				m0b = factor;
				m1a = a_deriv;
				m1b = factor;
			end
			default: ;
		endcase
	end

	assign p0 = m0a * m0b;
	assign p1 = m1a * m1b;
	assign p2 = a_deriv * b_real;

	logic               valid_s1;
	mode_t              mode_s1;
	logic [31:0]        ar_s1, ad_s1, br_s1, bd_s1, fac_s1;
	logic [63:0]        p0_s1, p1_s1, p2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode_in;
		ar_s1   <= a_real;
		ad_s1   <= a_deriv;
		br_s1   <= b_real;
		bd_s1   <= b_deriv;
		fac_s1  <= factor;
		p0_s1   <= p0;
		p1_s1   <= p1;
		p2_s1   <= p2;
	end

	// ---------------- stage 2: sums and divide setup ----------------
	lane_in_t    lr, ld;
	kind_t       kind;
	logic [64:0] tr, td, abs_ar, abs_ad, abs_br, abs_fac;

	assign abs_ar  = smag(sx32(ar_s1));
	assign abs_ad  = smag(sx32(ad_s1));
	assign abs_br  = smag(sx32(br_s1));
	assign abs_fac = smag(sx32(fac_s1));

	always_comb begin
		lr   = '0;
		ld   = '0;
		tr   = '0;
		td   = '0;
		kind = KIND_CALC;
		case (mode_s1)
			MODE_NEG: begin
				tr = smag(65'd0 - sx32(ar_s1));
				td = smag(65'd0 - sx32(ad_s1));
			end
			MODE_ADD: begin
				tr = smag(sx32(ar_s1) + sx32(br_s1));
				td = smag(sx32(ad_s1) + sx32(bd_s1));
			end
			MODE_SUB: begin
				tr = smag(sx32(ar_s1) - sx32(br_s1));
				td = smag(sx32(ad_s1) - sx32(bd_s1));
			end
			MODE_MUL: begin
				tr = smag(sx64(p0_s1));
				td = smag(sx64(p1_s1) + sx64(p2_s1));
				tr[63:0] = tr[63:0] >> FRAC_BITS;
				td[63:0] = td[63:0] >> FRAC_BITS;
			end
			MODE_SCALE: begin
				tr = smag(sx64(p0_s1));
				td = smag(sx64(p1_s1));
				tr[63:0] = tr[63:0] >> FRAC_BITS;
				td[63:0] = td[63:0] >> FRAC_BITS;
			end
			MODE_DIV: begin
				if (br_s1 == 32'd0) begin
					kind = KIND_DZ;
				end else begin
					// quotient rule: (ad*br - ar*bd) / br^2
					td = smag(sx64(p2_s1) - sx64(p1_s1));
				end
			end
			MODE_INV: begin
				if (fac_s1 == 32'd0) kind = KIND_DZ;
			end
			default: kind = KIND_ZERO;
		endcase

		lr.neg = tr[64];
		lr.num = tr[63:0];
		ld.neg = td[64];
		ld.num = td[63:0];

		if (mode_s1 == MODE_DIV) begin
			lr.div = 1'b1;
			lr.neg = ar_s1[31] ^ br_s1[31];
			lr.num = abs_ar[63:0];
			lr.den = abs_br[63:0];
			ld.div = 1'b1;
			ld.den = p0_s1;
		end else if (mode_s1 == MODE_INV) begin
			lr.div = 1'b1;
			lr.neg = ar_s1[31] ^ fac_s1[31];
			lr.num = abs_ar[63:0];
			lr.den = abs_fac[63:0];
			ld.div = 1'b1;
			ld.neg = ad_s1[31] ^ fac_s1[31];
			ld.num = abs_ad[63:0];
			ld.den = abs_fac[63:0];
		end
	end

	lane_in_t lr_s2, ld_s2;
	logic     valid_s2;
	kind_t    kind_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind;
		lr_s2   <= lr;
		ld_s2   <= ld;
	end

	// ---------------- divide lanes ----------------
	lane_out_t ro, dro;

	dna_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_real (
		.clk  (clk),
		.din  (lr_s2),
		.dout (ro)
	);

	dna_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_deriv (
		.clk  (clk),
		.din  (ld_s2),
		.dout (dro)
	);

	logic  mvalid_s [0:STEPS];
	kind_t mkind_s  [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STEPS; i++) mvalid_s[i] <= 1'b0;
		end else begin
			mvalid_s[0] <= valid_s2;
			for (int i = 1; i <= STEPS; i++) mvalid_s[i] <= mvalid_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		mkind_s[0] <= kind_s2;
		for (int i = 1; i <= STEPS; i++) mkind_s[i] <= mkind_s[i-1];
	end

	// ---------------- output register ----------------
	logic [32:0] qr, qd;
	logic        done_q;
	logic [31:0] res_real_q, res_deriv_q;
	logic [1:0]  status_q;

	assign qr = to_q(ro.neg, ro.mag);
	assign qd = to_q(dro.neg, dro.mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= mvalid_s[STEPS];
	end

	always_ff @(posedge clk) begin
		case (mkind_s[STEPS])
			KIND_CALC: begin
				res_real_q  <= qr[31:0];
				res_deriv_q <= qd[31:0];
				status_q    <= (qr[32] | qd[32]) ? STAT_SAT : STAT_OK;
			end
			KIND_DZ: begin
				res_real_q  <= '0;
				res_deriv_q <= '0;
				status_q    <= STAT_DZ;
			end
			default: begin
				res_real_q  <= '0;
				res_deriv_q <= '0;
				status_q    <= STAT_OK;
			end
		endcase
	end

	assign done      = done_q;
	assign res_real  = res_real_q;
	assign res_deriv = res_deriv_q;
	assign status    = status_q;

endmodule

[rtl/dna_checker.sv]
// ----------------------------------------------------------------------------
// dna_checker
// Port-level checks on the dual number pipeline: fixed latency and result
// consistency with the reported status.
// ----------------------------------------------------------------------------
module dna_checker
	import dna_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] res_real,
	input logic [31:0] res_deriv,
	input logic [1:0]  status
);

	localparam int LATENCY = 37;

	// every accepted transaction yields a result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after accepted transaction");

	// no result without a matching transaction
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without transaction");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_DZ) |-> (res_real == 32'd0 && res_deriv == 32'd0))
		else $error("divide by zero with nonzero result");

	// a saturated result has at least one part sitting on a bound
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_SAT) |->
			(res_real == 32'h7FFF_FFFF || res_real == 32'h8000_0000 ||
			 res_deriv == 32'h7FFF_FFFF || res_deriv == 32'h8000_0000))
		else $error("saturation status without bound value");

endmodule

bind dual_number_alu dna_checker u_dna_checker (.*);

[bench/dual_number_alu_tb.sv]
// ----------------------------------------------------------------------------
// dual_number_alu_tb
// Drives directed and random dual number operations into the ALU, predicts
// each result with exact wide arithmetic, and checks every done strobe in
// order against the predicted real part, derivative part and status.
// ----------------------------------------------------------------------------
module dual_number_alu_tb
	import dna_pkg::*;
();

	localparam int FRAC = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] de;
		logic [1:0]         st;
	} dual_res_t;

	typedef struct {
		bit           neg;
		logic [127:0] mag;
	} part_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         mode = MODE_NONE;
	logic signed [31:0] a_real = '0;
	logic signed [31:0] a_deriv = '0;
	logic signed [31:0] b_real = '0;
	logic signed [31:0] b_deriv = '0;
	logic signed [31:0] factor = '0;
	logic               done;
	logic signed [31:0] res_real;
	logic signed [31:0] res_deriv;
	logic [1:0]         status;

	dual_res_t pending_results[$];
	int        errors = 0;
	int        cycles = 0;
	bit        no_idle = 1'b0;

	dual_number_alu uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.a_real(a_real), .a_deriv(a_deriv), .b_real(b_real), .b_deriv(b_deriv),
		.factor(factor), .done(done), .res_real(res_real), .res_deriv(res_deriv),
		.status(status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// magnitude of v truncated by sh bits, sign kept apart
	function automatic part_t shifted_part(input logic signed [127:0] v, input int sh);
		part_t p;
		p.neg = v < 0;
		p.mag = (p.neg ? -v : v) >> sh;
		return p;
	endfunction

	function automatic part_t quot_part(input logic signed [127:0] num,
			input logic signed [127:0] den);
		part_t p;
		logic [127:0] n;
		logic [127:0] d;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		p.neg = (num < 0) != (den < 0);
		p.mag = (n << FRAC) / d;
		return p;
	endfunction

	function automatic logic [31:0] clamp_q(input part_t p, inout bit sat);
		if (!p.neg) begin
			if (p.mag > 128'h7FFF_FFFF) begin
				sat = 1'b1;
				return 32'h7FFF_FFFF;
			end
			return p.mag[31:0];
		end
		if (p.mag > 128'h8000_0000) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return -p.mag[31:0];
	endfunction

	function automatic dual_res_t predict_dual(input logic [2:0] op,
			input logic signed [31:0] ar, input logic signed [31:0] ad,
			input logic signed [31:0] br, input logic signed [31:0] bd,
			input logic signed [31:0] s);
		dual_res_t r;
		part_t pr;
		part_t pd;
		logic signed [127:0] xr;
		logic signed [127:0] xd;
		logic signed [127:0] yr;
		logic signed [127:0] yd;
		logic signed [127:0] xs;
		bit sat;
		bit calc;
		xr = ar; xd = ad; yr = br; yd = bd; xs = s;
		sat = 1'b0;
		calc = 1'b1;
		r.re = '0; r.de = '0; r.st = STAT_OK;
		pr = shifted_part(0, 0);
		pd = pr;
		case (op)
			MODE_NEG: begin
				pr = shifted_part(-xr, 0);
				pd = shifted_part(-xd, 0);
			end
			MODE_ADD: begin
				pr = shifted_part(xr + yr, 0);
				pd = shifted_part(xd + yd, 0);
			end
			MODE_SUB: begin
				pr = shifted_part(xr - yr, 0);
				pd = shifted_part(xd - yd, 0);
			end
			MODE_MUL: begin
				pr = shifted_part(xr * yr, FRAC);
				pd = shifted_part(xr * yd + xd * yr, FRAC);
			end
			MODE_DIV: begin
				if (br == 0) begin
					r.st = STAT_DZ;
					calc = 1'b0;
				end else begin
					pr = quot_part(xr, yr);
					pd = quot_part(xd * yr - xr * yd, yr * yr);
				end
			end
			MODE_SCALE: begin
				pr = shifted_part(xr * xs, FRAC);
				pd = shifted_part(xd * xs, FRAC);
			end
			MODE_INV: begin
				if (s == 0) begin
					r.st = STAT_DZ;
					calc = 1'b0;
				end else begin
					pr = quot_part(xr, xs);
					pd = quot_part(xd, xs);
				end
			end
			default: calc = 1'b0;
		endcase
		if (calc) begin
			r.re = clamp_q(pr, sat);
			r.de = clamp_q(pd, sat);
			if (sat)
				r.st = STAT_SAT;
		end
		return r;
	endfunction

	// checks results first, then records the transaction taken at this edge
	always @(posedge clk) begin
		dual_res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: %h %h %0d", res_real, res_deriv, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (res_real !== want.re) begin
					$error("res_real expected %h actual %h", want.re, res_real);
					errors++;
				end
				if (res_deriv !== want.de) begin
					$error("res_deriv expected %h actual %h", want.de, res_deriv);
					errors++;
				end
				if (status !== want.st) begin
					$error("status expected %0d actual %0d", want.st, status);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy)
			pending_results.push_back(predict_dual(mode, a_real, a_deriv, b_real,
				b_deriv, factor));
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_op(input logic [2:0] op, input logic signed [31:0] ar,
			input logic signed [31:0] ad, input logic signed [31:0] br,
			input logic signed [31:0] bd, input logic signed [31:0] s);
		bit taken;
		while (!no_idle && $urandom_range(99) < 28) begin
			@(negedge clk);
			start = 1'b0;
			mode = 3'($urandom);
			a_real = $urandom;
		end
		@(negedge clk);
		start = 1'b1;
		mode = op; a_real = ar; a_deriv = ad; b_real = br; b_deriv = bd; factor = s;
		forever begin
			taken = !busy;
			@(posedge clk);
			if (taken)
				break;
			@(negedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_val();
		case ($urandom_range(5))
			0: return $urandom_range(8) == 0 ? 0 : $signed($urandom_range(0, 32'h3_0000))
				- 32'sh1_8000;
			1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			2: return $signed($urandom) >>> $urandom_range(31);
			3: return $urandom_range(1) ? 32'sh1_0000 : -32'sh1_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [2:0] op;
		for (int m = MODE_NEG; m <= MODE_NONE; m++) begin
			op = 3'(m);
			send_op(op, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
				32'sh8000_0000);
			send_op(op, 32'sh3_0000, -32'sh1_8000, 32'sh2_0000, 32'sh0_4000, 32'sh0_8000);
		end
		send_op(MODE_NEG, 32'sh8000_0000, 0, 0, 0, 0);           // negating min saturates
		send_op(MODE_DIV, 32'sh1_0000, 32'sh1_0000, 0, 32'sh5, 1); // zero divisor
		send_op(MODE_INV, 32'sh1_0000, 32'sh1_0000, 1, 1, 0);
		send_op(MODE_DIV, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 0);
		send_op(MODE_INV, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, -1);
		send_op(MODE_MUL, -1, 1, 1, -1, 0);                      // truncation toward zero
		send_op(MODE_SCALE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF);
		send_op(MODE_ADD, -1, -1, -1, -1, -1);
	endtask

	task automatic test_random(input int count, input bit steady);
		logic [2:0] op;
		no_idle = steady;
		repeat (count) begin
			op = 3'($urandom_range(7));
			send_op(op, pick_val(), pick_val(), pick_val(), pick_val(), pick_val());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(500, 1'b0);
		test_random(250, 1'b1);
		test_random(480, 1'b0);
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
